[design/mlps_pkg.sv]
// ----------------------------------------------------------------------------
// mlps_pkg: shared types and constants for the minimum largest part sum block
// Beat formats of the input and result channels and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package mlps_pkg;

  localparam int ELEMENT_W    = 16;  // width of the element field on the port
  localparam int ELEMENT_EXT_W = 32; // element widened before masking
  localparam int SUM_OUT_W    = 24;  // width of the result sum field
  localparam int PART_COUNT_W = 9;   // width of the part count register
  localparam int PARTS_W      = 10;  // part counter, may reach one past the register maximum

  typedef struct packed {
    logic [ELEMENT_W-1:0] element;
    logic                 last;
  } in_item_t;

  typedef struct packed {
    logic [SUM_OUT_W-1:0] largest_sum;
    logic                 overflow;
  } out_item_t;

endpackage

`default_nettype wire

[design/mlps_store.sv]
// ----------------------------------------------------------------------------
// mlps_store: element store
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mlps_store #(
  parameter int DEPTH  = 256,
  parameter int DATA_W = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[design/min_largest_part_sum_top.sv]
// ----------------------------------------------------------------------------
// min_largest_part_sum_top: smallest achievable largest part sum
// Loads an array and binary-searches the least limit under which it splits
// greedily into at most part_count contiguous parts.
// ----------------------------------------------------------------------------
// Usage. Array elements arrive one beat at a time on the in_* channel; the
// beat with last set closes the set. Loading accepts one beat per cycle. Once
// the closing beat is taken the block drops in_ready and searches between
// the largest element and the total. Each probe forms the midpoint and then
// walks the N stored elements through the registered read port of the store,
// stopping early when the probe fails. Exactly one result beat appears on
// out_* per set. Elements arriving with the store already full are dropped,
// and the result of that set carries overflow. part_count is written
// through the cfg_* channel, which is always ready; a value of zero acts as
// one. Write it only while the block is idle.
// Reset (synchronous, rst high) empties the set, sets part_count to one and
// clears out_valid. The store contents are not cleared. A result beat that
// the receiver stalls is held in the output register; the next set may load
// meanwhile, but its own result waits until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module min_largest_part_sum_top
  import mlps_pkg::*;
#(
  parameter int STORE_DEPTH  = 256,
  parameter int ELEMENT_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire in_item_t                in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output out_item_t                    out_data,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [PART_COUNT_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int SUM_W  = ELEMENT_BITS + CNT_W;

  // Sequencer states.
  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]              state;
  logic [PART_COUNT_W-1:0] part_count;
  logic [CNT_W-1:0]        loaded_count;
  logic [ELEMENT_BITS-1:0] running_max;
  logic [SUM_W-1:0]        running_total;
  logic                    dropped_flag;
  logic [SUM_W-1:0]        search_low;
  logic [SUM_W-1:0]        search_high;
  logic [SUM_W-1:0]        probe_limit;
  logic [SUM_W-1:0]        probe_sum;
  logic [PARTS_W-1:0]      parts_used;
  logic [CNT_W-1:0]        issue_idx;
  logic                    rd_pend;

  logic [ELEMENT_EXT_W-1:0] elem_ext;
  logic [ELEMENT_BITS-1:0]  elem_val;
  logic                     in_fire;
  logic                     store_room;
  logic                     issue_more;
  logic [ELEMENT_BITS-1:0]  rd_data;
  logic [SUM_W:0]           mid_wide;
  logic [SUM_W:0]           sum_add;
  logic                     sum_fits;
  logic [PARTS_W-1:0]       parts_inc;
  logic [PARTS_W-1:0]       allowed;
  logic                     probe_fail;
  logic                     walk_end;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_LOAD);
  assign in_fire   = in_valid && in_ready;

  // Elements are masked to the configured element width.
  assign elem_ext   = ELEMENT_EXT_W'(in_data.element);
  assign elem_val   = elem_ext[ELEMENT_BITS-1:0];
  assign store_room = (loaded_count < CNT_W'(STORE_DEPTH));

  assign issue_more = (issue_idx < loaded_count);

  // Midpoint of the search window, rounded down; low never exceeds high here.
  assign mid_wide = ({1'b0, search_low} + {1'b0, search_high}) >> 1;

  // Greedy step of the walk on the element just read.
  assign sum_add  = {1'b0, probe_sum} + (SUM_W + 1)'(rd_data);
  assign sum_fits = (sum_add <= {1'b0, probe_limit});
  assign parts_inc = parts_used + PARTS_W'(1);
  assign allowed   = (part_count == '0) ? PARTS_W'(1) : PARTS_W'(part_count);
  assign probe_fail = rd_pend && !sum_fits &&
                      ((parts_inc > allowed) || (SUM_W'(rd_data) > probe_limit));
  assign walk_end   = !issue_more && !rd_pend;

  mlps_store #(
    .DEPTH  (STORE_DEPTH),
    .DATA_W (ELEMENT_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_fire && store_room),
    .wr_addr (loaded_count[ADDR_W-1:0]),
    .wr_data (elem_val),
    .rd_en   ((state == ST_WALK) && issue_more),
    .rd_addr (issue_idx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      part_count <= PART_COUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      part_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      loaded_count  <= '0;
      running_max   <= '0;
      running_total <= '0;
      dropped_flag  <= 1'b0;
      rd_pend       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // In ST_DONE the handover below decides out_valid on its own.
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_LOAD: begin
          if (in_fire) begin
            if (store_room) begin
              loaded_count  <= loaded_count + CNT_W'(1);
              running_total <= running_total + SUM_W'(elem_val);
              if (elem_val > running_max) begin
                running_max <= elem_val;
              end
            end else begin
              dropped_flag <= 1'b1;
            end
            if (in_data.last) begin
              state <= ST_INIT;
            end
          end
        end

        ST_INIT: begin
          search_low  <= SUM_W'(running_max);
          search_high <= running_total;
          state       <= ST_CHECK;
        end

        ST_CHECK: begin
          if (search_low < search_high) begin
            probe_limit <= mid_wide[SUM_W-1:0];
            probe_sum   <= '0;
            parts_used  <= PARTS_W'(1);
            issue_idx   <= '0;
            rd_pend     <= 1'b0;
            state       <= ST_WALK;
          end else begin
            state <= ST_DONE;
          end
        end

        ST_WALK: begin
          rd_pend <= issue_more && !probe_fail;
          if (issue_more) begin
            issue_idx <= issue_idx + CNT_W'(1);
          end
          if (rd_pend) begin
            if (sum_fits) begin
              probe_sum <= sum_add[SUM_W-1:0];
            end else begin
              parts_used <= parts_inc;
              probe_sum  <= SUM_W'(rd_data);
            end
          end
          if (probe_fail) begin
            search_low <= probe_limit + SUM_W'(1);
            state      <= ST_CHECK;
          end else if (walk_end) begin
            search_high <= probe_limit;
            state       <= ST_CHECK;
          end
        end

        ST_DONE: begin
          // Wait for the output register to free up before handing over.
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            loaded_count  <= '0;
            running_max   <= '0;
            running_total <= '0;
            dropped_flag  <= 1'b0;
            state         <= ST_LOAD;
          end
        end

        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Result payload; captured together with out_valid going high.
  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!out_valid || out_ready)) begin
      out_data.largest_sum <= SUM_OUT_W'(search_low);
      out_data.overflow    <= dropped_flag;
    end
  end

endmodule

`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for min_largest_part_sum_top
// Feeds sets of array elements through the input channel, with bursts, gaps
// and a stalling receiver. A shadow calculation of the smallest largest part
// sum predicts every result beat, and each one is compared field by field.
// ----------------------------------------------------------------------------
module tb;
  import mlps_pkg::*;

  localparam int DEPTH       = 256;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int DIR_ROWS    = 25;

  // One row of the directed table. A row may first reprogram the part count
  // (once the block has gone idle). Where the answer is obvious it is typed
  // in, otherwise the shadow calculation supplies it.
  typedef struct {
    bit                    wr_cfg;
    logic [PART_COUNT_W-1:0] cfg;
    logic [ELEMENT_W-1:0]  element;
    bit                    last;
    bit                    typed;
    logic [SUM_OUT_W-1:0]  sum;
    bit                    ovf;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    in_valid = 1'b0;
  logic                    in_ready;
  in_item_t                in_data = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  out_item_t               out_data;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [PART_COUNT_W-1:0] cfg_data = '0;

  min_largest_part_sum_top #(
    .STORE_DEPTH  (DEPTH),
    .ELEMENT_BITS (16)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the block's state, advanced on every accepted input beat.
  logic [ELEMENT_W-1:0]    shadow_store [DEPTH];
  int unsigned             shadow_count = 0;
  longint unsigned         shadow_peak = 0;
  longint unsigned         shadow_total = 0;
  bit                      shadow_dropped = 1'b0;
  logic [PART_COUNT_W-1:0] shadow_parts = 9'd1;

  out_item_t expected_results [$];
  bit        failed = 1'b0;
  int        burst_left = 0;
  int        cycle_count = 0;

  // Greedy walk over the loaded elements: true when the set splits into no
  // more than the allowed number of parts with no part sum above the cap.
  function automatic bit split_fits(longint unsigned cap, int unsigned allowed);
    longint unsigned acc;
    int unsigned     pieces;
    acc = 0;
    pieces = 1;
    for (int i = 0; i < shadow_count; i++) begin
      if (acc + shadow_store[i] <= cap) begin
        acc += 64'(shadow_store[i]);
      end else begin
        pieces++;
        if (pieces > allowed || shadow_store[i] > cap) return 1'b0;
        acc = 64'(shadow_store[i]);
      end
    end
    return 1'b1;
  endfunction

  // Loads one element into the shadow state. On the closing beat it runs the
  // binary search, fills in the result and empties the set; the part count
  // survives from set to set.
  function automatic bit load_and_solve(in_item_t beat, output out_item_t res);
    int unsigned     allowed;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    res = '0;
    if (shadow_count < DEPTH) begin
      shadow_store[shadow_count] = beat.element;
      shadow_count++;
      if (beat.element > shadow_peak) shadow_peak = 64'(beat.element);
      shadow_total += 64'(beat.element);
    end else begin
      // The store is full, so the element is lost and the set is flagged.
      shadow_dropped = 1'b1;
    end
    if (!beat.last) return 1'b0;
    // A part count of zero behaves as one.
    allowed = (shadow_parts == 0) ? 1 : shadow_parts;
    lo = shadow_peak;
    hi = shadow_total;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (split_fits(mid, allowed)) hi = mid;
      else lo = mid + 1;
    end
    res.largest_sum = lo[SUM_OUT_W-1:0];
    res.overflow    = shadow_dropped;
    shadow_count   = 0;
    shadow_peak    = 0;
    shadow_total   = 0;
    shadow_dropped = 1'b0;
    return 1'b1;
  endfunction

  // Element values lean towards the extremes and towards small numbers, so
  // that ties and zero-sum parts turn up often.
  function automatic logic [ELEMENT_W-1:0] rand_element();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return ELEMENT_W'($urandom_range(0, 15));
      default: return ELEMENT_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Sends one beat. The sender works in bursts; at the start of each burst
  // it may sit idle for a while, now and then for a long stretch.
  task automatic push_beat(input logic [ELEMENT_W-1:0] value, input bit closes,
                           input bit use_typed, input out_item_t typed_res);
    in_item_t  beat;
    out_item_t res;
    int        gap;
    beat.element = value;
    beat.last    = closes;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 2);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (load_and_solve(beat, res)) expected_results.push_back(use_typed ? typed_res : res);
  endtask

  // Holds the sender off until every outstanding result beat has arrived.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // The part count may only change while the block is idle, so drain first
  // and give it a short grace period before the write.
  task automatic set_part_count(input logic [PART_COUNT_W-1:0] value);
    wait_for_results();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_parts = value;
  endtask

  // Directed part. It starts with the reset part count of one, where the
  // answer is simply the total, then covers a zero count, a pair of classic
  // two-part splits, more parts than elements and the widest count.
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{1'b0, 9'd0,   16'd0,     1'b1, 1'b1, 24'd0,      1'b0},
    '{1'b0, 9'd0,   16'hFFFF,  1'b1, 1'b1, 24'd65535,  1'b0},
    '{1'b0, 9'd0,   16'd1,     1'b0, 1'b0, 24'd0,      1'b0},
    '{1'b0, 9'd0,   16'd2,     1'b0, 1'b0, 24'd0,      1'b0},
    '{1'b0, 9'd0,   16'd3,     1'b1, 1'b1, 24'd6,      1'b0},
    '{1'b0, 9'd0,   16'hFFFF,  1'b0, 1'b0, 24'd0,      1'b0},
    '{1'b0, 9'd0,   16'hFFFF,  1'b1, 1'b1, 24'd131070, 1'b0},
    '{1'b1, 9'd0,   16'd5,     1'b0, 1'b0, 24'd0,      1'b0},
    '{1'b0, 9'd0,   16'd7,     1'b1, 1'b1, 24'd12,     1'b0},
    '{1'b1, 9'd2,   16'd7,     1'b0, 1'b0, 24'd0,      1'b0},
    '{1'b0, 9'd0,   16'd2,     1'b0, 1'b0, 24'd0,      1'b0},
    '{1'b0, 9'd0,   16'd5,     1'b0, 1'b0, 24'd0,      1'b0},
    '{1'b0, 9'd0,   16'd10,    1'b0, 1'b0, 24'd0,      1'b0},
    '{1'b0, 9'd0,   16'd8,     1'b1, 1'b0, 24'd0,      1'b0},
    '{1'b0, 9'd0,   16'd1,     1'b0, 1'b0, 24'd0,      1'b0},
    '{1'b0, 9'd0,   16'd2,     1'b0, 1'b0, 24'd0,      1'b0},
    '{1'b0, 9'd0,   16'd3,     1'b0, 1'b0, 24'd0,      1'b0},
    '{1'b0, 9'd0,   16'd4,     1'b0, 1'b0, 24'd0,      1'b0},
    '{1'b0, 9'd0,   16'd5,     1'b1, 1'b0, 24'd0,      1'b0},
    '{1'b1, 9'd511, 16'd9,     1'b0, 1'b0, 24'd0,      1'b0},
    '{1'b0, 9'd0,   16'd3,     1'b0, 1'b0, 24'd0,      1'b0},
    '{1'b0, 9'd0,   16'd4,     1'b1, 1'b1, 24'd9,      1'b0},
    '{1'b1, 9'd256, 16'd0,     1'b0, 1'b0, 24'd0,      1'b0},
    '{1'b0, 9'd0,   16'd0,     1'b0, 1'b0, 24'd0,      1'b0},
    '{1'b0, 9'd0,   16'd0,     1'b1, 1'b1, 24'd0,      1'b0}
  };

  // Part counts for the random phases. Two of them are drawn after the directed part.
  logic [PART_COUNT_W-1:0] phase_parts [9] = '{
    9'd2, 9'd0, 9'd3, 9'd256, 9'd511, 9'd5, 9'd1, 9'd40, 9'd255
  };

  initial begin
    out_item_t typed_res;
    int        sent;
    int        len;
    int        extra;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].wr_cfg) set_part_count(directed_rows[r].cfg);
      typed_res.largest_sum = directed_rows[r].sum;
      typed_res.overflow    = directed_rows[r].ovf;
      push_beat(directed_rows[r].element, directed_rows[r].last, directed_rows[r].typed,
                typed_res);
    end

    phase_parts[5] = PART_COUNT_W'($urandom_range(4, 8));
    phase_parts[7] = PART_COUNT_W'($urandom_range(9, 255));
    foreach (phase_parts[p]) begin
      set_part_count(phase_parts[p]);
      if (phase_parts[p] == 1) begin
        // One oversized set: the store fills with the largest element, which
        // gives the widest possible sum, and a few beats beyond the depth
        // are dropped, the closing beat among them.
        extra = $urandom_range(1, 3);
        for (int k = 0; k < DEPTH + extra; k++)
          push_beat((k < DEPTH) ? 16'hFFFF : rand_element(), k == DEPTH + extra - 1,
                    1'b0, '0);
      end
      sent = 0;
      while (sent < 36) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
        for (int k = 0; k < len; k++)
          push_beat(rand_element(), k == len - 1, 1'b0, '0);
        sent += len;
        // Now and then the sender waits for the block to catch up fully.
        if ($urandom_range(0, 9) == 0) wait_for_results();
      end
    end

    // Drain, then watch a little longer for any stray result beat.
    wait_for_results();
    repeat (50) @(posedge clk);
    if (failed || expected_results.size() != 0) begin
      $display("Test completed with failures");
    end else begin
      $display("Test completed successfully");
    end
    $finish;
  end

  // The receiver moves between three moods: always ready, ready about half
  // the time, and mostly stalled. Each mood lasts a random number of cycles.
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(20, 300);
    end
    mode_left--;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Result checker: every accepted result beat is matched against the oldest
  // expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: largest_sum %0d, overflow %0b",
               out_data.largest_sum, out_data.overflow);
        failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (out_data.largest_sum !== want.largest_sum) begin
          $error("largest_sum mismatch: expected %0d, actual %0d",
                 want.largest_sum, out_data.largest_sum);
          failed = 1'b1;
        end
        if (out_data.overflow !== want.overflow) begin
          $error("overflow mismatch: expected %0b, actual %0b",
                 want.overflow, out_data.overflow);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog against a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

[files.f]
design/mlps_pkg.sv
design/mlps_store.sv
design/min_largest_part_sum_top.sv
bench/tb.sv
